// File: rtl/sha384_pkg.sv
// shared types, constants and round functions of the sha-384 hash core
package sha384_pkg;

   localparam int WORD_W      = 64;
   localparam int BLOCK_WORDS = 16;
   localparam int HASH_WORDS  = 8;
   localparam int NUM_ROUNDS  = 80;
   localparam int DIGEST_WORDS = 6;
   localparam int POS_W       = $clog2(BLOCK_WORDS);
   localparam int ROUND_W     = $clog2(NUM_ROUNDS);
   localparam int IDX_W       = $clog2(HASH_WORDS);

   localparam logic [POS_W-1:0]   POS_LAST   = POS_W'(BLOCK_WORDS - 1);
   localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(NUM_ROUNDS - 1);
   localparam logic [IDX_W-1:0]   DIGEST_LAST_IDX = IDX_W'(DIGEST_WORDS - 1);

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic [63:0] message_word;
      logic        starts_message;
      logic        ends_message;
   } req_type;

   typedef struct packed {
      logic [63:0] digest_word;
      logic [2:0]  digest_index;
      logic        digest_last;
   } rsp_type;

   typedef struct packed {
      logic               load_word;
      logic               load_iv;
      logic               init_vars;
      logic               round;
      logic [ROUND_W-1:0] round_idx;
      logic               finalize;
      logic               emit;
      logic [IDX_W-1:0]   emit_idx;
   } cmd_type;

   function automatic word_type iv_word(input logic [IDX_W-1:0] idx);
      word_type r;
      case (idx)
         3'd0: r = 64'hcbbb9d5dc1059ed8;
         3'd1: r = 64'h629a292a367cd507;
         3'd2: r = 64'h9159015a3070dd17;
         3'd3: r = 64'h152fecd8f70e5939;
         3'd4: r = 64'h67332667ffc00b31;
         3'd5: r = 64'h8eb44a8768581511;
         3'd6: r = 64'hdb0c2e0d64f98fa7;
         default: r = 64'h47b5481dbefa4fa4;
      endcase
      return r;
   endfunction

   function automatic word_type round_k(input logic [ROUND_W-1:0] idx);
      word_type r;
      case (idx)
         7'd0:  r = 64'h428a2f98d728ae22;
         7'd1:  r = 64'h7137449123ef65cd;
         7'd2:  r = 64'hb5c0fbcfec4d3b2f;
         7'd3:  r = 64'he9b5dba58189dbbc;
         7'd4:  r = 64'h3956c25bf348b538;
         7'd5:  r = 64'h59f111f1b605d019;
         7'd6:  r = 64'h923f82a4af194f9b;
         7'd7:  r = 64'hab1c5ed5da6d8118;
         7'd8:  r = 64'hd807aa98a3030242;
         7'd9:  r = 64'h12835b0145706fbe;
         7'd10: r = 64'h243185be4ee4b28c;
         7'd11: r = 64'h550c7dc3d5ffb4e2;
         7'd12: r = 64'h72be5d74f27b896f;
         7'd13: r = 64'h80deb1fe3b1696b1;
         7'd14: r = 64'h9bdc06a725c71235;
         7'd15: r = 64'hc19bf174cf692694;
         7'd16: r = 64'he49b69c19ef14ad2;
         7'd17: r = 64'hefbe4786384f25e3;
         7'd18: r = 64'h0fc19dc68b8cd5b5;
         7'd19: r = 64'h240ca1cc77ac9c65;
         7'd20: r = 64'h2de92c6f592b0275;
         7'd21: r = 64'h4a7484aa6ea6e483;
         7'd22: r = 64'h5cb0a9dcbd41fbd4;
         7'd23: r = 64'h76f988da831153b5;
         7'd24: r = 64'h983e5152ee66dfab;
         7'd25: r = 64'ha831c66d2db43210;
         7'd26: r = 64'hb00327c898fb213f;
         7'd27: r = 64'hbf597fc7beef0ee4;
         7'd28: r = 64'hc6e00bf33da88fc2;
         7'd29: r = 64'hd5a79147930aa725;
         7'd30: r = 64'h06ca6351e003826f;
         7'd31: r = 64'h142929670a0e6e70;
         7'd32: r = 64'h27b70a8546d22ffc;
         7'd33: r = 64'h2e1b21385c26c926;
         7'd34: r = 64'h4d2c6dfc5ac42aed;
         7'd35: r = 64'h53380d139d95b3df;
         7'd36: r = 64'h650a73548baf63de;
         7'd37: r = 64'h766a0abb3c77b2a8;
         7'd38: r = 64'h81c2c92e47edaee6;
         7'd39: r = 64'h92722c851482353b;
         7'd40: r = 64'ha2bfe8a14cf10364;
         7'd41: r = 64'ha81a664bbc423001;
         7'd42: r = 64'hc24b8b70d0f89791;
         7'd43: r = 64'hc76c51a30654be30;
         7'd44: r = 64'hd192e819d6ef5218;
         7'd45: r = 64'hd69906245565a910;
         7'd46: r = 64'hf40e35855771202a;
         7'd47: r = 64'h106aa07032bbd1b8;
         7'd48: r = 64'h19a4c116b8d2d0c8;
         7'd49: r = 64'h1e376c085141ab53;
         7'd50: r = 64'h2748774cdf8eeb99;
         7'd51: r = 64'h34b0bcb5e19b48a8;
         7'd52: r = 64'h391c0cb3c5c95a63;
         7'd53: r = 64'h4ed8aa4ae3418acb;
         7'd54: r = 64'h5b9cca4f7763e373;
         7'd55: r = 64'h682e6ff3d6b2b8a3;
         7'd56: r = 64'h748f82ee5defb2fc;
         7'd57: r = 64'h78a5636f43172f60;
         7'd58: r = 64'h84c87814a1f0ab72;
         7'd59: r = 64'h8cc702081a6439ec;
         7'd60: r = 64'h90befffa23631e28;
         7'd61: r = 64'ha4506cebde82bde9;
         7'd62: r = 64'hbef9a3f7b2c67915;
         7'd63: r = 64'hc67178f2e372532b;
         7'd64: r = 64'hca273eceea26619c;
         7'd65: r = 64'hd186b8c721c0c207;
         7'd66: r = 64'heada7dd6cde0eb1e;
         7'd67: r = 64'hf57d4f7fee6ed178;
         7'd68: r = 64'h06f067aa72176fba;
         7'd69: r = 64'h0a637dc5a2c898a6;
         7'd70: r = 64'h113f9804bef90dae;
         7'd71: r = 64'h1b710b35131c471b;
         7'd72: r = 64'h28db77f523047d84;
         7'd73: r = 64'h32caab7b40c72493;
         7'd74: r = 64'h3c9ebe0a15c9bebc;
         7'd75: r = 64'h431d67c49c100d4c;
         7'd76: r = 64'h4cc5d4becb3e42b6;
         7'd77: r = 64'h597f299cfc657e2a;
         7'd78: r = 64'h5fcb6fab3ad6faec;
         7'd79: r = 64'h6c44198c4a475817;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      return {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ {7'd0, x[63:7]};
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ {6'd0, x[63:6]};
   endfunction

endpackage

// File: rtl/sha384_ctrl.sv
// controller state machine: word position, round count and digest sequencing
module sha384_ctrl
   import sha384_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    starts_message,
   input  logic    ends_message,
   output logic    busy,
   output logic    rsp_valid,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ROUND,
      S_FINAL,
      S_OUTPUT
   } state_type;

   state_type          state_ff, state_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic [IDX_W-1:0]   out_idx_ff, out_idx_in;
   logic               ends_ff, ends_in;
   logic               valid_ff, valid_in;
   logic               accept;
   logic [POS_W-1:0]   pos_eff;

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;
   assign accept    = start && !busy;
   assign pos_eff   = starts_message ? '0 : pos_ff;

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      round_in   = round_ff;
      out_idx_in = out_idx_ff;
      ends_in    = ends_ff;
      valid_in   = 1'b0;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load_word = 1'b1;
               cmd.load_iv   = starts_message;
               if (pos_eff == POS_LAST) begin
                  cmd.init_vars = 1'b1;
                  pos_in        = '0;
                  round_in      = '0;
                  ends_in       = ends_message;
                  state_in      = S_ROUND;
               end else begin
                  pos_in = pos_eff + POS_W'(1);
               end
            end
         end
         S_ROUND: begin
            cmd.round     = 1'b1;
            cmd.round_idx = round_ff;
            round_in      = round_ff + ROUND_W'(1);
            if (round_ff == ROUND_LAST) begin
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            cmd.finalize = 1'b1;
            out_idx_in   = '0;
            state_in     = ends_ff ? S_OUTPUT : S_IDLE;
         end
         S_OUTPUT: begin
            cmd.emit     = 1'b1;
            cmd.emit_idx = out_idx_ff;
            valid_in     = 1'b1;
            out_idx_in   = out_idx_ff + IDX_W'(1);
            if (out_idx_ff == DIGEST_LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         pos_ff     <= '0;
         round_ff   <= '0;
         out_idx_ff <= '0;
         ends_ff    <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         round_ff   <= round_in;
         out_idx_ff <= out_idx_in;
         ends_ff    <= ends_in;
         valid_ff   <= valid_in;
      end
   end

endmodule

// File: rtl/sha384_dp.sv
// datapath: schedule window, working variables, chaining value and result register
module sha384_dp
   import sha384_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   input  word_type message_word,
   output rsp_type  rsp_data
);

   word_type sched_ff [BLOCK_WORDS];
   word_type sched_in [BLOCK_WORDS];
   word_type vars_ff  [HASH_WORDS];
   word_type vars_in  [HASH_WORDS];
   word_type chain_ff [HASH_WORDS];
   word_type chain_in [HASH_WORDS];
   rsp_type  rsp_ff, rsp_in;
   word_type expanded;
   word_type t1;
   word_type t2;
   word_type choose;
   word_type major;

   assign rsp_data = rsp_ff;

   // next schedule word from the sliding window
   assign expanded = sched_ff[0] + small_sigma0(sched_ff[1]) + sched_ff[9]
                   + small_sigma1(sched_ff[14]);

   assign choose = (vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]);
   assign major  = (vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
                 ^ (vars_ff[1] & vars_ff[2]);
   assign t1 = vars_ff[7] + big_sigma1(vars_ff[4]) + choose + round_k(cmd.round_idx)
             + sched_ff[0];
   assign t2 = big_sigma0(vars_ff[0]) + major;

   always_comb begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
         sched_in[i] = sched_ff[i + 1];
      end
      sched_in[BLOCK_WORDS - 1] = cmd.load_word ? message_word : expanded;

      for (int i = 0; i < HASH_WORDS; i++) begin
         vars_in[i]  = vars_ff[i];
         chain_in[i] = chain_ff[i];
      end
      if (cmd.init_vars) begin
         for (int i = 0; i < HASH_WORDS; i++) begin
            vars_in[i] = chain_ff[i];
         end
      end else if (cmd.round) begin
         vars_in[7] = vars_ff[6];
         vars_in[6] = vars_ff[5];
         vars_in[5] = vars_ff[4];
         vars_in[4] = vars_ff[3] + t1;
         vars_in[3] = vars_ff[2];
         vars_in[2] = vars_ff[1];
         vars_in[1] = vars_ff[0];
         vars_in[0] = t1 + t2;
      end
      if (cmd.load_iv) begin
         for (int i = 0; i < HASH_WORDS; i++) begin
            chain_in[i] = iv_word(IDX_W'(i));
         end
      end else if (cmd.finalize) begin
         for (int i = 0; i < HASH_WORDS; i++) begin
            chain_in[i] = chain_ff[i] + vars_ff[i];
         end
      end

      rsp_in              = rsp_ff;
      rsp_in.digest_word  = chain_ff[cmd.emit_idx];
      rsp_in.digest_index = cmd.emit_idx;
      rsp_in.digest_last  = (cmd.emit_idx == DIGEST_LAST_IDX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HASH_WORDS; i++) begin
            chain_ff[i] <= iv_word(IDX_W'(i));
            vars_ff[i]  <= '0;
         end
      end else begin
         for (int i = 0; i < HASH_WORDS; i++) begin
            chain_ff[i] <= chain_in[i];
            vars_ff[i]  <= vars_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_word || cmd.round) begin
         for (int i = 0; i < BLOCK_WORDS; i++) begin
            sched_ff[i] <= sched_in[i];
         end
      end
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// File: rtl/sha384_hash_core.sv
// top level of the sha-384 hash core: controller and datapath
//
//  channel   ports                      handshake
//  request   start, busy, req_data      taken when start high and busy low
//  result    rsp_valid, rsp_data        one cycle per digest word, no stall
//
// a request is taken while busy is low; the sixteenth word of a block then holds
// busy through 80 rounds on one shared round unit and one chaining add, and
// through the digest output when it ends the message; no word is taken meanwhile.
// digest words appear on consecutive cycles, most significant first.
// synchronous reset loads the initial hash and clears the word position.
module sha384_hash_core
   import sha384_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   cmd_type cmd;

   sha384_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .starts_message (req_data.starts_message),
      .ends_message   (req_data.ends_message),
      .busy           (busy),
      .rsp_valid      (rsp_valid),
      .cmd            (cmd)
   );

   sha384_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .message_word (req_data.message_word),
      .rsp_data     (rsp_data)
   );

endmodule
